FILE: sv/nfza_pkg.sv
// Shared types, constants and sequencer opcodes for the next-fit zone allocator.
package nfza_pkg;

    localparam int ARENA_WORDS  = 16384;
    localparam int AW           = $clog2(ARENA_WORDS);
    localparam int SZ_W         = AW + 1;
    localparam int HEADER_BYTES = 20;
    localparam int BYTES_W      = SZ_W + 2;
    localparam int ADDR_W       = 16;
    localparam int REQ_W        = 16;
    localparam int FRAG_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 40;

    localparam logic [SZ_W-1:0]    ARENA_SZ       = SZ_W'(ARENA_WORDS);
    localparam logic [BYTES_W-1:0] ARENA_BYTES    = BYTES_W'(ARENA_WORDS * 4);
    localparam logic [FRAG_W-1:0]  MIN_FRAG_RESET = FRAG_W'(48);

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_START    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_CLEAR   = 4'd1;
    localparam op_t OP_LOAD    = 4'd2;
    localparam op_t OP_A_CHK   = 4'd3;
    localparam op_t OP_A_SPLIT = 4'd4;
    localparam op_t OP_A_AFTER = 4'd5;
    localparam op_t OP_A_FIN   = 4'd6;
    localparam op_t OP_F_B     = 4'd7;
    localparam op_t OP_F_P     = 4'd8;
    localparam op_t OP_F_NRD   = 4'd9;
    localparam op_t OP_F_N     = 4'd10;
    localparam op_t OP_F_NN    = 4'd11;
    localparam op_t OP_F_WB    = 4'd12;
    localparam op_t OP_EMIT    = 4'd13;

    typedef struct packed {
        logic            start;
        logic            inuse;
        logic [SZ_W-1:0] size;
        logic [AW-1:0]   back;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic addr_bad;
        logic hdr_start;
        logic hdr_inuse;
        logic b_nonzero;
        logic fit;
        logic lap_done;
        logic split;
        logic after_ok;
        logic nx_ok;
        logic nn_ok;
        logic nx_free;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: sv/next_fit_zone_allocator_core.sv
// Top level of the next-fit zone allocator: stream ports, sequencer and datapath.
// Usage: the arena of 16384 words is tracked as a block header RAM walked by a
// sequencer, one RAM read per cycle. After reset a clearing pass writes every
// header, during which s_axis_tready stays low. An allocate visits blocks from
// the rover until one fits, splits off the remainder when it is larger than the
// minimum fragment, updates the neighbor after a split block if there is one,
// and writes the allocated header; a failed lap visits every block in the arena.
// A free of a low or misaligned address goes straight to the result, one of an
// address that is not an in-use block start reads that header first, and any
// other free runs read-modify-write steps on the neighbor headers. The result
// word is held in an output register, and the next command is accepted while it waits.
module next_fit_zone_allocator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [nfza_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // request_bytes, block_address
    input  logic                                s_axis_tuser,  // cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [nfza_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // payload_address, free_bytes
    output logic [nfza_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nfza_pkg::FRAG_W-1:0]         cfg_data       // min_fragment_bytes
);
    import nfza_pkg::*;

    op_t     op;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    nfza_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .op       (op)
    );

    nfza_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

FILE: sv/nfza_ram.sv
// Generic simple dual-port RAM with registered read.
module nfza_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/nfza_ctrl.sv
// Sequencer that steps the allocator datapath through clear, allocate and free.
module nfza_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  nfza_pkg::dp_sts_t sts,
    input  logic              in_valid,
    output logic              in_ready,
    output nfza_pkg::op_t     op
);
    import nfza_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_CHK   = 4'd2;
    localparam logic [3:0] S_A_SPLIT = 4'd3;
    localparam logic [3:0] S_A_AFTER = 4'd4;
    localparam logic [3:0] S_A_FIN   = 4'd5;
    localparam logic [3:0] S_F_B     = 4'd6;
    localparam logic [3:0] S_F_P     = 4'd7;
    localparam logic [3:0] S_F_NRD   = 4'd8;
    localparam logic [3:0] S_F_N     = 4'd9;
    localparam logic [3:0] S_F_NN    = 4'd10;
    localparam logic [3:0] S_F_WB    = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    if (!sts.is_free)
                    begin
                        state_next = S_A_CHK;
                    end
                    else if (sts.addr_bad)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_F_B;
                    end
                end
            end
            S_A_CHK:
            begin
                op = OP_A_CHK;
                if (sts.fit)
                begin
                    state_next = S_A_SPLIT;
                end
                else if (sts.lap_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_A_SPLIT:
            begin
                op         = OP_A_SPLIT;
                state_next = (sts.split && sts.after_ok) ? S_A_AFTER : S_A_FIN;
            end
            S_A_AFTER:
            begin
                op         = OP_A_AFTER;
                state_next = S_A_FIN;
            end
            S_A_FIN:
            begin
                op         = OP_A_FIN;
                state_next = S_EMIT;
            end
            S_F_B:
            begin
                op = OP_F_B;
                if (!sts.hdr_start || !sts.hdr_inuse)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = sts.b_nonzero ? S_F_P : S_F_NRD;
                end
            end
            S_F_P:
            begin
                op         = OP_F_P;
                state_next = S_F_NRD;
            end
            S_F_NRD:
            begin
                op         = OP_F_NRD;
                state_next = sts.nx_ok ? S_F_N : S_F_WB;
            end
            S_F_N:
            begin
                op         = OP_F_N;
                state_next = (sts.nx_free && sts.nn_ok) ? S_F_NN : S_F_WB;
            end
            S_F_NN:
            begin
                op         = OP_F_NN;
                state_next = S_F_WB;
            end
            S_F_WB:
            begin
                op         = OP_F_WB;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input taken during clearing pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD) |-> in_valid && in_ready)
        else $error("load without accepted word");
    assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_A_FIN || op == OP_F_WB) |=> (state_reg == S_EMIT))
        else $error("finished step not followed by emit");

endmodule

FILE: sv/nfza_dp.sv
// Datapath of the allocator: header RAM, rover, byte count and result registers.
module nfza_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nfza_pkg::op_t                    op,
    output nfza_pkg::dp_sts_t                sts,
    input  logic [nfza_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                             in_user,
    input  logic                             cfg_valid,
    input  logic [nfza_pkg::FRAG_W-1:0]      cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nfza_pkg::OUT_DATA_W-1:0]  out_data,
    output logic [nfza_pkg::STATUS_W-1:0]    out_user
);
    import nfza_pkg::*;

    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]      rover_reg, rover_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      nx_reg, nx_next;
    logic [AW-1:0]      nn_reg, nn_next;
    logic [SZ_W-1:0]    need_reg, need_next;
    logic [BYTES_W-1:0] used_reg, used_next;
    logic [FRAG_W-1:0]  frag_reg;
    hdr_t               hdr_reg, hdr_next;
    logic               merged_reg, merged_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTES_W-1:0] out_free_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    hdr_t               ram_wdata;
    logic [HDR_W-1:0]   ram_rbits;
    hdr_t               rdata;

    logic [REQ_W-1:0]   req;
    logic [ADDR_W-1:0]  faddr;
    logic [ADDR_W-1:0]  sb;
    logic [SZ_W-1:0]    follow;
    logic [AW-1:0]      next_cur;
    logic [SZ_W-1:0]    extra;
    logic [AW-1:0]      nb;
    logic [SZ_W-1:0]    after;
    logic [SZ_W-1:0]    fin_size;
    logic [SZ_W-1:0]    fin_follow;
    logic [SZ_W-1:0]    nx_full;
    logic [SZ_W-1:0]    nsize;
    logic [SZ_W-1:0]    nn_full;
    hdr_t               reset_hdr;

    nfza_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_WORDS)) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign rdata = hdr_t'(ram_rbits);
    assign req   = in_data[REQ_W-1:0];
    assign faddr = in_data[REQ_W +: ADDR_W];
    assign sb    = faddr - ADDR_W'(HEADER_BYTES);

    assign reset_hdr = '{start: 1'b1, inuse: 1'b0, size: ARENA_SZ, back: '0};

    assign follow     = {1'b0, cur_reg} + rdata.size;
    assign next_cur   = (follow >= ARENA_SZ) ? '0 : follow[AW-1:0];
    assign extra      = hdr_reg.size - need_reg;
    assign nb         = cur_reg + need_reg[AW-1:0];
    assign after      = {1'b0, cur_reg} + hdr_reg.size;
    assign fin_size   = sts.split ? need_reg : hdr_reg.size;
    assign fin_follow = {1'b0, cur_reg} + fin_size;
    assign nx_full    = {1'b0, base_reg} + hdr_reg.size;
    assign nsize      = hdr_reg.size + rdata.size;
    assign nn_full    = {1'b0, base_reg} + nsize;

    always_comb
    begin
        sts           = '0;
        sts.clr_last  = &clr_cnt_reg;
        sts.is_free   = (in_user == CMD_FREE);
        sts.addr_bad  = (faddr < ADDR_W'(HEADER_BYTES)) || (sb[1:0] != 2'b00);
        sts.hdr_start = rdata.start;
        sts.hdr_inuse = rdata.inuse;
        sts.b_nonzero = (base_reg != '0);
        sts.fit       = !rdata.inuse && (rdata.size >= need_reg);
        sts.lap_done  = (next_cur == rover_reg);
        sts.split     = ({extra, 2'b00} > BYTES_W'(frag_reg));
        sts.after_ok  = (after < ARENA_SZ);
        sts.nx_ok     = (nx_full < ARENA_SZ);
        sts.nx_free   = !rdata.inuse;
        sts.nn_ok     = (nn_full < ARENA_SZ);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        rover_next      = rover_reg;
        cur_next        = cur_reg;
        base_next       = base_reg;
        nx_next         = nx_reg;
        nn_next         = nn_reg;
        need_next       = need_reg;
        used_next       = used_reg;
        hdr_next        = hdr_reg;
        merged_next     = merged_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = hdr_reg;
        ram_raddr       = cur_reg;
        case (op)
            OP_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = (clr_cnt_reg == '0) ? reset_hdr : '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            OP_LOAD:
            begin
                res_addr_next = '0;
                merged_next   = 1'b0;
                if (in_user == CMD_ALLOC)
                begin
                    cur_next        = rover_reg;
                    ram_raddr       = rover_reg;
                    need_next       = SZ_W'((BYTES_W'(req) + BYTES_W'(HEADER_BYTES + 7)) >> 2);
                    res_status_next = ST_NO_SPACE;
                end
                else
                begin
                    ram_raddr       = sb[2 +: AW];
                    base_next       = sb[2 +: AW];
                    res_status_next = sts.addr_bad ? ST_NOT_START : ST_OK;
                end
            end
            OP_A_CHK:
            begin
                hdr_next = rdata;
                if (!sts.fit)
                begin
                    cur_next  = next_cur;
                    ram_raddr = next_cur;
                end
            end
            OP_A_SPLIT:
            begin
                if (sts.split)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = nb;
                    ram_wdata = '{start: 1'b1, inuse: 1'b0, size: extra, back: cur_reg};
                    ram_raddr = after[AW-1:0];
                end
            end
            OP_A_AFTER:
            begin
                ram_we         = 1'b1;
                ram_waddr      = after[AW-1:0];
                ram_wdata      = rdata;
                ram_wdata.back = nb;
            end
            OP_A_FIN:
            begin
                ram_we          = 1'b1;
                ram_waddr       = cur_reg;
                ram_wdata       = '{start: 1'b1, inuse: 1'b1, size: fin_size,
                                    back: hdr_reg.back};
                rover_next      = (fin_follow >= ARENA_SZ) ? '0 : fin_follow[AW-1:0];
                used_next       = used_reg + {fin_size, 2'b00};
                res_addr_next   = {cur_reg, 2'b00} + ADDR_W'(HEADER_BYTES);
                res_status_next = ST_OK;
            end
            OP_F_B:
            begin
                hdr_next       = rdata;
                hdr_next.inuse = 1'b0;
                ram_raddr      = rdata.back;
                if (!rdata.start)
                begin
                    res_status_next = ST_NOT_START;
                end
                else if (!rdata.inuse)
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    used_next = used_reg - {rdata.size, 2'b00};
                end
            end
            OP_F_P:
            begin
                ram_we    = 1'b1;
                ram_waddr = base_reg;
                if (!rdata.inuse)
                begin
                    ram_wdata       = hdr_reg;
                    ram_wdata.start = 1'b0;
                    base_next       = hdr_reg.back;
                    hdr_next        = rdata;
                    hdr_next.size   = rdata.size + hdr_reg.size;
                    merged_next     = 1'b1;
                end
            end
            OP_F_NRD:
            begin
                ram_raddr = nx_full[AW-1:0];
                nx_next   = nx_full[AW-1:0];
            end
            OP_F_N:
            begin
                ram_we    = 1'b1;
                ram_waddr = nx_reg;
                ram_wdata = rdata;
                if (merged_reg)
                begin
                    ram_wdata.back = base_reg;
                end
                if (!rdata.inuse)
                begin
                    ram_wdata.start = 1'b0;
                    hdr_next.size   = nsize;
                    ram_raddr       = nn_full[AW-1:0];
                    nn_next         = nn_full[AW-1:0];
                end
            end
            OP_F_NN:
            begin
                ram_we         = 1'b1;
                ram_waddr      = nn_reg;
                ram_wdata      = rdata;
                ram_wdata.back = base_reg;
            end
            OP_F_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = base_reg;
                ram_wdata  = hdr_reg;
                rover_next = base_reg;
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rover_reg     <= '0;
            used_reg      <= '0;
            frag_reg      <= MIN_FRAG_RESET;
            merged_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            rover_reg     <= rover_next;
            used_reg      <= used_next;
            merged_reg    <= merged_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                frag_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        base_reg       <= base_next;
        nx_reg         <= nx_next;
        nn_reg         <= nn_next;
        need_reg       <= need_next;
        hdr_reg        <= hdr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (op == OP_EMIT)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_free_reg   <= ARENA_BYTES - used_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {(OUT_DATA_W - ADDR_W - BYTES_W)'(0), out_free_reg, out_addr_reg};
    assign out_user  = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op == OP_EMIT))
        else $error("result word raised without emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(op == OP_A_FIN || op == OP_F_WB) |=> $stable(rover_reg))
        else $error("rover moved outside a finishing step");
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ARENA_BYTES)
        else $error("used byte count beyond arena");

endmodule
